[rtl/sliding_window_peak_score_defines.svh]
// Assertion macros shared by the sliding-window peak score RTL
`ifndef SLIDING_WINDOW_PEAK_SCORE_DEFINES_SVH
`define SLIDING_WINDOW_PEAK_SCORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// clocked check, off while reset is high
`define SWPS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// clocked check, also live during reset
`define SWPS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define SWPS_ASSERT(label, prop, msg)
`define SWPS_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

[rtl/swps_pkg.sv]
// Types, sizes and divider constants for the sliding-window peak score block
`timescale 1ns / 1ps
package swps_pkg;

   localparam int MAG_W   = 16;
   localparam int TIME_W  = 32;
   localparam int SCORE_W = 17;
   localparam int QUOT_W  = 16;

   localparam int WINDOW   = 15;
   localparam int HELD     = WINDOW - 1;
   localparam int OLD_CELL = WINDOW - 2;
   localparam int MID_CELL = WINDOW - 2 - WINDOW / 2;
   localparam int CNT_W    = $clog2(WINDOW);
   localparam int SUM_W    = MAG_W + $clog2(WINDOW);

   // divide by WINDOW-1 through a truncated reciprocal and one correction
   localparam int      DIVISOR = WINDOW - 1;
   localparam int      ABS_W   = $clog2(DIVISOR * 65535 + 1);
   localparam longint  RECIP   = (longint'(1) << ABS_W) / DIVISOR;
   localparam int      RECIP_W = $clog2(RECIP + 1);

   localparam int REQ_DATA_W = ((MAG_W + TIME_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((TIME_W + SCORE_W + 7) / 8) * 8;

   typedef struct packed {
      logic [TIME_W-1:0]       stamp;
      logic signed [MAG_W-1:0] magnitude;
   } sample_type;

   typedef struct packed {
      logic [TIME_W-1:0]       stamp;
      logic signed [MAG_W-1:0] mid;
      logic signed [SUM_W-1:0] total;
   } score_req_type;

endpackage

[rtl/swps_cell.sv]
// One delay-line cell: holds a sample and passes it on to its neighbour
`timescale 1ns / 1ps
module swps_cell (
   input  logic                 clock,
   input  logic                 shift,
   input  swps_pkg::sample_type sample_in,
   output swps_pkg::sample_type sample_out
);

   swps_pkg::sample_type sample_ff;

   // advance the line on every accepted request
   always_ff @(posedge clock) begin
      if (shift) begin
         sample_ff <= sample_in;
      end
   end

   assign sample_out = sample_ff;

endmodule

[rtl/swps_scorer.sv]
// Score pipeline: numerator, reciprocal multiply, correction and output register
`timescale 1ns / 1ps
`include "sliding_window_peak_score_defines.svh"
module swps_scorer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  swps_pkg::score_req_type              in_req,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [swps_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   localparam int AW = swps_pkg::ABS_W;
   localparam int PW = swps_pkg::ABS_W + swps_pkg::RECIP_W;

   // numerator stage
   logic                              num_valid_ff;
   logic                              num_neg_ff;
   logic [AW-1:0]                     num_abs_ff;
   logic [swps_pkg::TIME_W-1:0]       num_stamp_ff;
   // reciprocal stage
   logic                              quo_valid_ff;
   logic                              quo_neg_ff;
   logic [AW-1:0]                     quo_abs_ff;
   logic [swps_pkg::QUOT_W-1:0]       quo_est_ff;
   logic [swps_pkg::TIME_W-1:0]       quo_stamp_ff;
   // output register
   logic                              out_valid_ff;
   logic signed [swps_pkg::SCORE_W-1:0] out_score_ff;
   logic [swps_pkg::TIME_W-1:0]       out_stamp_ff;

   logic                              out_ready;
   logic                              quo_ready;
   logic signed [swps_pkg::SUM_W:0]   wide_mid;
   logic signed [swps_pkg::SUM_W:0]   scaled;
   logic signed [swps_pkg::SUM_W:0]   numer;
   logic signed [swps_pkg::SUM_W:0]   numer_mag;
   logic [PW-1:0]                     prod;
   logic [AW-1:0]                     rem;
   logic [swps_pkg::QUOT_W-1:0]       quot;
   logic signed [swps_pkg::SCORE_W-1:0] quot_s;
   logic signed [swps_pkg::SCORE_W-1:0] score;

   // each stage moves on when the one ahead is empty or moving
   assign out_ready = !out_valid_ff || rsp_tready;
   assign quo_ready = !quo_valid_ff || out_ready;
   assign in_ready  = !num_valid_ff || quo_ready;

   // numerator: WINDOW * middle minus the full window sum, then split sign
   assign wide_mid  = {{(swps_pkg::SUM_W + 1 - swps_pkg::MAG_W){in_req.mid[swps_pkg::MAG_W-1]}},
                       in_req.mid};
   assign scaled    = wide_mid * $signed((swps_pkg::SUM_W + 1)'(swps_pkg::WINDOW));
   assign numer     = scaled - {in_req.total[swps_pkg::SUM_W-1], in_req.total};
   assign numer_mag = numer[swps_pkg::SUM_W] ? -numer : numer;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_valid_ff <= 1'b0;
      end else if (in_ready) begin
         num_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         num_neg_ff   <= numer[swps_pkg::SUM_W];
         num_abs_ff   <= numer_mag[AW-1:0];
         num_stamp_ff <= in_req.stamp;
      end
   end

   // quotient estimate: at most one below the true quotient
   assign prod = PW'(num_abs_ff) * PW'(swps_pkg::RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         quo_valid_ff <= 1'b0;
      end else if (quo_ready) begin
         quo_valid_ff <= num_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (quo_ready && num_valid_ff) begin
         quo_neg_ff   <= num_neg_ff;
         quo_abs_ff   <= num_abs_ff;
         quo_est_ff   <= prod[AW +: swps_pkg::QUOT_W];
         quo_stamp_ff <= num_stamp_ff;
      end
   end

   // correct the estimate and restore the sign (truncation toward zero)
   assign rem    = quo_abs_ff - AW'(AW'(swps_pkg::DIVISOR) * AW'(quo_est_ff));
   assign quot   = (rem >= AW'(swps_pkg::DIVISOR)) ? quo_est_ff + 1'b1 : quo_est_ff;
   assign quot_s = $signed({1'b0, quot});
   assign score  = quo_neg_ff ? -quot_s : quot_s;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= quo_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && quo_valid_ff) begin
         out_score_ff <= score;
         out_stamp_ff <= quo_stamp_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(swps_pkg::RSP_DATA_W - swps_pkg::TIME_W - swps_pkg::SCORE_W){1'b0}},
                        out_score_ff, out_stamp_ff};

   `SWPS_ASSERT(a_rem_bound, quo_valid_ff |-> (rem < AW'(2 * swps_pkg::DIVISOR)), "reciprocal estimate off by more than one")
   `SWPS_ASSERT(a_score_range, out_valid_ff |-> (out_score_ff != {1'b1, {(swps_pkg::SCORE_W-1){1'b0}}}), "score out of range")

endmodule

[rtl/sliding_window_peak_score.sv]
// Top level: sample delay line, running sum and score pipeline
//
//  channel | direction | contents
//  req     | in        | tdata[15:0] sample_magnitude, tdata[47:16] sample_time
//  rsp     | out       | tdata[31:0] score_time, tdata[48:32] peak_score, rest zero
//
// One request per cycle while rsp does not stall; the request that fills the window
// passes through the s1 register, then the numerator, reciprocal and output registers.
// The first WINDOW-1 requests after reset only fill the delay line and give no result.
// Reset is synchronous; it empties the window and the pipeline.
// A stall on rsp backs up through the pipeline registers before req_tready drops.
`timescale 1ns / 1ps
`include "sliding_window_peak_score_defines.svh"
module sliding_window_peak_score (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [swps_pkg::REQ_DATA_W-1:0]      req_tdata,  // sample_magnitude, sample_time
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [swps_pkg::RSP_DATA_W-1:0]      rsp_tdata   // score_time, peak_score
);

   swps_pkg::sample_type           new_sample;
   swps_pkg::sample_type           chain [swps_pkg::HELD+1];
   logic [swps_pkg::CNT_W-1:0]     fill_ff;
   logic [swps_pkg::CNT_W-1:0]     fill_in;
   logic signed [swps_pkg::SUM_W-1:0] sum_ff;
   logic signed [swps_pkg::SUM_W-1:0] sum_in;
   logic signed [swps_pkg::SUM_W-1:0] total;
   logic signed [swps_pkg::SUM_W-1:0] oldest;
   logic                           full;
   logic                           accept;
   logic                           s1_valid_ff;
   swps_pkg::score_req_type        s1_req_ff;
   logic                           sc_ready;
   logic                           s1_ready;

   assign new_sample.magnitude = $signed(req_tdata[swps_pkg::MAG_W-1:0]);
   assign new_sample.stamp     = req_tdata[swps_pkg::MAG_W +: swps_pkg::TIME_W];

   assign s1_ready   = !s1_valid_ff || sc_ready;
   assign req_tready = s1_ready;
   assign accept     = req_tvalid && req_tready;
   assign full       = (fill_ff == swps_pkg::CNT_W'(swps_pkg::HELD));

   // delay line: cell k holds the sample k+1 requests back
   assign chain[0] = new_sample;
   for (genvar k = 0; k < swps_pkg::HELD; k++) begin : g_cell
      swps_cell u_cell (
         .clock      (clock),
         .shift      (accept),
         .sample_in  (chain[k]),
         .sample_out (chain[k+1])
      );
   end

   // running sum over the held samples; drop the oldest once the window is full
   assign total  = sum_ff + swps_pkg::SUM_W'(new_sample.magnitude);
   assign oldest = full ? swps_pkg::SUM_W'(chain[swps_pkg::OLD_CELL+1].magnitude) : '0;
   assign sum_in = total - oldest;
   assign fill_in = full ? fill_ff : fill_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         sum_ff  <= '0;
      end else if (accept) begin
         fill_ff <= fill_in;
         sum_ff  <= sum_in;
      end
   end

   // hold the middle sample and the full sum for the score pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= accept && full;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && full) begin
         s1_req_ff.stamp <= chain[swps_pkg::MID_CELL+1].stamp;
         s1_req_ff.mid   <= chain[swps_pkg::MID_CELL+1].magnitude;
         s1_req_ff.total <= total;
      end
   end

   swps_scorer u_scorer (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s1_valid_ff),
      .in_ready   (sc_ready),
      .in_req     (s1_req_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   `SWPS_ASSERT(a_fill_bound, (fill_ff <= swps_pkg::CNT_W'(swps_pkg::HELD)), "fill count beyond window")
   `SWPS_ASSERT(a_empty_sum, (fill_ff == '0) |-> (sum_ff == '0), "sum not zero with empty window")
   `SWPS_ASSERT(a_fill_step, (accept && !full) |=> (fill_ff == $past(fill_ff) + 1'b1), "fill count did not advance")

endmodule

[test/sliding_window_peak_score_checker.sv]
// Checker for the sliding-window peak score block: window predictor and result compare
`timescale 1ns / 1ps
module sliding_window_peak_score_checker
   import swps_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // sample_magnitude, sample_time
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // score_time, peak_score
   output int                    mismatch_count,
   output int                    pending_scores,
   output int                    scores_checked
);

   typedef struct {
      logic [TIME_W-1:0]         stamp;
      logic signed [SCORE_W-1:0] score;
   } peak_score_type;

   // predictor copy of the window, oldest sample at index 0
   logic signed [MAG_W-1:0] held_mag [WINDOW];
   logic [TIME_W-1:0]       held_stamp [WINDOW];
   int                      held_count;
   longint                  held_sum;
   peak_score_type          expected_scores [$];
   int                      errors;
   int                      checked;

   initial begin
      mismatch_count = 0;
      pending_scores = 0;
      scores_checked = 0;
      held_count     = 0;
      held_sum       = 0;
      errors         = 0;
      checked        = 0;
   end

   task automatic report_mismatch(input string what);
      $display("[%0t] score mismatch: %s", $realtime, what);
      errors++;
   endtask

   // store one sample; once the window is full, queue its score and drop the oldest
   task automatic slide_window(input logic signed [MAG_W-1:0] mag,
                               input logic [TIME_W-1:0] stamp);
      longint         centre;
      longint         numer;
      peak_score_type item;
      int             i;
      held_mag[held_count]   = mag;
      held_stamp[held_count] = stamp;
      held_sum               += mag;
      held_count++;
      if (held_count == WINDOW) begin
         centre     = held_mag[WINDOW / 2];
         numer      = WINDOW * centre - held_sum;
         item.stamp = held_stamp[WINDOW / 2];
         // signed division truncates toward zero
         item.score = SCORE_W'(numer / (WINDOW - 1));
         expected_scores.push_back(item);
         held_sum -= held_mag[0];
         for (i = 0; i < WINDOW - 1; i++) begin
            held_mag[i]   = held_mag[i + 1];
            held_stamp[i] = held_stamp[i + 1];
         end
         held_count = WINDOW - 1;
      end
   endtask

   always @(posedge clock) begin
      peak_score_type            want;
      logic [TIME_W-1:0]         got_stamp;
      logic signed [SCORE_W-1:0] got_score;
      if (reset) begin
         held_count = 0;
         held_sum   = 0;
         expected_scores.delete();
      end else begin
         // predict from each accepted request
         if (req_tvalid && req_tready)
            slide_window(req_tdata[MAG_W-1:0], req_tdata[MAG_W +: TIME_W]);
         // compare each accepted result with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got_stamp = rsp_tdata[TIME_W-1:0];
            got_score = rsp_tdata[TIME_W +: SCORE_W];
            if (expected_scores.size() == 0) begin
               report_mismatch($sformatf("unexpected result time %0h score %0d",
                                         got_stamp, got_score));
            end else begin
               want = expected_scores.pop_front();
               checked++;
               if (got_stamp !== want.stamp)
                  report_mismatch($sformatf("score_time %0h, want %0h",
                                            got_stamp, want.stamp));
               if (got_score !== want.score)
                  report_mismatch($sformatf("peak_score %0d, want %0d (time %0h)",
                                            got_score, want.score, want.stamp));
            end
         end
      end
      mismatch_count <= errors;
      pending_scores <= expected_scores.size();
      scores_checked <= checked;
   end

endmodule

[test/sliding_window_peak_score_tb.sv]
// Testbench top for the sliding-window peak score block: stimulus, idling phases and verdict
`timescale 1ns / 1ps
module sliding_window_peak_score_tb;
   import swps_pkg::*;

   localparam int PHASE_SAMPLES = 245;
   localparam int SETTLE_CYCLES = 16;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // sample_magnitude, sample_time
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // score_time, peak_score

   int mismatch_count;
   int pending_scores;
   int scores_checked;
   int send_idle_pct;
   int stall_pct;
   int samples_sent;

   logic signed [MAG_W-1:0] last_mag;
   logic [TIME_W-1:0]       last_stamp;

   sliding_window_peak_score dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   sliding_window_peak_score_checker score_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .pending_scores (pending_scores),
      .scores_checked (scores_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: stall at the rate of the current phase
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // hard limit on the run
   initial begin
      #2_000_000;
      $display("sliding_window_peak_score_tb failed");
      $finish;
   end

   // offer one sample after a random idle gap and hold it until accepted
   task automatic send_sample(input logic signed [MAG_W-1:0] mag,
                              input logic [TIME_W-1:0] stamp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_W - MAG_W - TIME_W){1'b0}}, stamp, mag};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      last_mag   = mag;
      last_stamp = stamp;
      samples_sent++;
   endtask

   // hold off requests until every predicted score has arrived
   task automatic drain_scores;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_scores != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mix of full-range values, extremes, values near zero and flat runs
   function automatic logic signed [MAG_W-1:0] pick_magnitude();
      case ($urandom_range(9))
         0:       return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
         1, 2:    return MAG_W'($signed($urandom_range(6)) - 3);
         3:       return last_mag;
         default: return MAG_W'($urandom);
      endcase
   endfunction

   // mostly rising timestamps, sometimes arbitrary or at the ends of the range
   function automatic logic [TIME_W-1:0] pick_stamp();
      case ($urandom_range(7))
         0:       return $urandom_range(1) ? '1 : '0;
         1, 2:    return TIME_W'($urandom);
         default: return last_stamp + TIME_W'($urandom_range(1, 40));
      endcase
   endfunction

   initial begin
      int idle_table  [4];
      int stall_table [4];
      int k;
      int p;
      logic signed [MAG_W-1:0] mag;
      logic [TIME_W-1:0]       stamp;

      idle_table  = '{0, 67, 0, 38};
      stall_table = '{0, 0, 67, 38};
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      rsp_tready    = 1'b0;
      send_idle_pct = 0;
      stall_pct     = 0;
      samples_sent  = 0;
      last_mag      = '0;
      last_stamp    = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: first fourteen samples fill the window silently; the middle
      // sample at the top against a floor gives the largest score, then the
      // middle sample at the floor against the top gives the smallest
      for (k = 0; k < 30; k++) begin
         if (k == 7 || (k >= 15 && k != 22))
            mag = 16'sh7fff;
         else
            mag = 16'sh8000;
         case (k % 3)
            0:       stamp = '0;
            1:       stamp = '1;
            default: stamp = TIME_W'(32'h5a5a_0000 + k);
         endcase
         send_sample(mag, stamp);
      end
      drain_scores();

      // random phases with different idle and stall rates, drained between phases
      for (p = 0; p < 4; p++) begin
         send_idle_pct =  idle_table[p];
         stall_pct     <= stall_table[p];
         for (k = 0; k < PHASE_SAMPLES; k++)
            send_sample(pick_magnitude(), pick_stamp());
         drain_scores();
      end

      $display("run covered %0d samples and %0d checked scores", samples_sent, scores_checked);
      $display("phases: free-running, sender idling, receiver stalling, both");
      if (mismatch_count == 0 && pending_scores == 0) begin
         $display("sliding_window_peak_score_tb passed");
      end else begin
         $display("sliding_window_peak_score_tb failed");
      end
      $finish;
   end

endmodule
